// File: rtl/pic_pkg.sv
// Package for the programmable interval clock.
// Holds action and command codes, the rate constant and the divider handshake types.
// No dependencies.
package pic_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned STEP_W  = $clog2(DATA_W);

	// Dividend of the rate command
	localparam logic [DATA_W-1:0] RATE_NUM = 16'd60000;

	// Action codes of a request
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_CMD  = 2'd1;
	localparam logic [1:0] ACT_POLL = 2'd2;

	// Command numbers carried in reg_a
	localparam logic [DATA_W-1:0] CMD_RATE = 16'd0;
	localparam logic [DATA_W-1:0] CMD_READ = 16'd1;
	localparam logic [DATA_W-1:0] CMD_MSG  = 16'd2;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/pic_req_if.sv
// Request channel interface of the programmable interval clock.
// Depends on pic_pkg for field widths.
interface pic_req_if import pic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [DATA_W-1:0] reg_a;
	logic [DATA_W-1:0] reg_b;

	modport source (output valid, action, reg_a, reg_b, input ready);
	modport sink   (input valid, action, reg_a, reg_b, output ready);
endinterface

// File: rtl/pic_rsp_if.sv
// Response channel interface of the programmable interval clock.
// Depends on pic_pkg for field widths.
interface pic_rsp_if import pic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              read_valid;
	logic [DATA_W-1:0] read_data;
	logic              irq_valid;
	logic [DATA_W-1:0] irq_message;

	modport source (output valid, read_valid, read_data, irq_valid, irq_message, input ready);
	modport sink   (input valid, read_valid, read_data, irq_valid, irq_message, output ready);
endinterface

// File: rtl/pic_div.sv
// Bit-serial restoring divider: RATE_NUM divided by a 16-bit divisor.
// One quotient bit per cycle through shift registers. Depends on pic_pkg.
module pic_div import pic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t ctl,
	output div_rsp_t sts
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic              done_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W+1:0] diff;
	logic              ge;

	// Shift the next dividend bit into the partial remainder and try a subtract
	always_comb begin
		trial = {rem_q, num_q[DATA_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		ge    = ~diff[DATA_W+1];
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= RATE_NUM;
			dvs_q <= ctl.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DATA_W-2:0], 1'b0};
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
	end

	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

// File: rtl/programmable_interval_clock.sv
// Programmable interval clock: counts periods of 60000/B millisecond ticks.
// Depends on pic_pkg, pic_req_if, pic_rsp_if and pic_div.
//
// Each request is a millisecond tick, a command (reg_a selects: 0 set rate from reg_b,
// 1 read the 16-bit wrapping period count, 2 set the interrupt message) or an interrupt
// poll, and each request yields exactly one response. Ticks, polls and all commands but a
// nonzero rate leave the block idle; the next request may follow at once provided the response
// register is empty or its response is taken in that same cycle. A rate command with
// nonzero reg_b runs the bit-serial divider for 60000/reg_b and holds off new requests
// until the divider is done; its response (all zeros) is issued when the request is taken.
// A quotient of zero is clamped to a 1 ms period; reg_b of zero stops the clock. Rate
// commands clear the count and the phase.
module programmable_interval_clock import pic_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	pic_req_if.sink      req,
	pic_rsp_if.source    rsp
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic              state_q;
	logic              enabled_q;
	logic [DATA_W-1:0] period_q;
	logic [DATA_W-1:0] elapsed_q;
	logic [DATA_W-1:0] count_q;
	logic              pending_q;
	logic [DATA_W-1:0] message_q;

	logic              out_valid_q;
	logic              read_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic              irq_valid_q;
	logic [DATA_W-1:0] irq_message_q;

	logic              accept;
	logic [DATA_W-1:0] elapsed_nx;
	div_req_t          div_ctl;
	div_rsp_t          div_sts;

	assign req.ready  = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept     = req.valid && req.ready;
	assign elapsed_nx = elapsed_q + 1'b1;

	// Launch the divider for a nonzero rate command
	assign div_ctl.start   = accept && (req.action == ACT_CMD) && (req.reg_a == CMD_RATE)
		&& (req.reg_b != '0);
	assign div_ctl.divisor = req.reg_b;

	pic_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	// Clock state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enabled_q <= 1'b0;
			period_q  <= '0;
			elapsed_q <= '0;
			count_q   <= '0;
			pending_q <= 1'b0;
			message_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_TICK: begin
								if (enabled_q) begin
									if (elapsed_nx >= period_q) begin
										elapsed_q <= '0;
										count_q   <= count_q + 1'b1;
										pending_q <= (message_q != '0);
									end else begin
										elapsed_q <= elapsed_nx;
									end
								end
							end
							ACT_CMD: begin
								unique case (req.reg_a)
									CMD_RATE: begin
										count_q   <= '0;
										elapsed_q <= '0;
										if (req.reg_b != '0) begin
											state_q <= ST_DIV;
										end else begin
											enabled_q <= 1'b0;
										end
									end
									CMD_MSG: message_q <= req.reg_b;
									default: ;
								endcase
							end
							ACT_POLL: begin
								if (pending_q && (message_q != '0)) begin
									pending_q <= 1'b0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					// Clamp a zero quotient to one millisecond
					if (div_sts.done) begin
						period_q  <= (div_sts.quotient == '0) ? DATA_W'(1) : div_sts.quotient;
						enabled_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Response valid: set on request, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_valid_q  <= 1'b0;
			read_data_q   <= '0;
			irq_valid_q   <= 1'b0;
			irq_message_q <= '0;
			if ((req.action == ACT_CMD) && (req.reg_a == CMD_READ)) begin
				read_valid_q <= 1'b1;
				read_data_q  <= count_q;
			end
			if ((req.action == ACT_POLL) && pending_q && (message_q != '0)) begin
				irq_valid_q   <= 1'b1;
				irq_message_q <= message_q;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_valid  = read_valid_q;
	assign rsp.read_data   = read_data_q;
	assign rsp.irq_valid   = irq_valid_q;
	assign rsp.irq_message = irq_message_q;

endmodule
